### sv/bab_pkg.sv
// Shared types and constants for the battery alarm beeper.
package bab_pkg;

    // Request codes carried in req_type
    typedef enum logic [1:0] {
        REQ_TICK = 2'd0,
        REQ_ADC  = 2'd1,
        REQ_BEEP = 2'd2,
        REQ_NONE = 2'd3
    } req_t;

    // Configuration register indexes
    localparam logic [2:0] CFG_LOW_THRESHOLD  = 3'd0;
    localparam logic [2:0] CFG_LOW_HOLD       = 3'd1;
    localparam logic [2:0] CFG_TICKS_PER_MS   = 3'd2;
    localparam logic [2:0] CFG_TONE_HALF      = 3'd3;
    localparam logic [2:0] CFG_CADENCE_ON     = 3'd4;
    localparam logic [2:0] CFG_CADENCE_PERIOD = 3'd5;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Millivolt conversion: mean * 1875 / 128, saturated to 14 bits
    localparam int          MV_W     = 14;
    localparam int          MV_NUM_W = 11;
    localparam int          MV_NUM   = 1875;
    localparam int          MV_SHIFT = 7;
    localparam logic [13:0] MV_MAX   = 14'h3FFF;

    // Double beep timeline in milliseconds
    localparam logic [7:0] BEEP_GAP_START = 8'd80;
    localparam logic [7:0] BEEP_ON2_START = 8'd130;
    localparam logic [7:0] BEEP_END       = 8'd210;

    localparam logic [15:0] LOW_MS_MAX = 16'hFFFF;

    // Configuration register file
    typedef struct packed {
        logic [13:0] low_threshold_mv;
        logic [15:0] low_hold_ms;
        logic [3:0]  ticks_per_ms;
        logic [2:0]  tone_half_ticks;
        logic [13:0] cadence_on_ticks;
        logic [13:0] cadence_period_ticks;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        low_threshold_mv:     14'd5500,
        low_hold_ms:          16'd5000,
        ticks_per_ms:         4'd10,
        tone_half_ticks:      3'd2,
        cadence_on_ticks:     14'd5000,
        cadence_period_ticks: 14'd10000
    };

    // Per-item strobes, already qualified by the stage advancing
    typedef struct packed {
        logic tick;
        logic adc;
        logic beep;
    } step_t;

endpackage

### sv/battery_alarm_beeper_core.sv
// Top level of the battery alarm beeper: handshakes, config, stage registers.
//
//  channel   | valid / ready          | payload
//  ----------+------------------------+--------------------------------------
//  input     | in_valid / in_ready    | req_type, adc_sample
//  result    | out_valid / out_ready  | buzzer_level, alarm_on, battery_mv
//  config    | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One item per cycle sustained while the result side is not stalled; an item is
// taken into the input register and its state update goes into the result register.
// Reset clears the valid flags and sub-block state and loads the default config; no clearing pass.
// A stalled result holds the result register, and the input register then
// holds one more item before in_ready drops. Config writes are always taken.
module battery_alarm_beeper_core #(
    parameter int ADC_SAMPLES = 8,
    parameter int ADC_BITS    = 10
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [1:0]                     req_type,
    input  logic [ADC_BITS-1:0]            adc_sample,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           buzzer_level,
    output logic                           alarm_on,
    output logic [bab_pkg::MV_W-1:0]       battery_mv,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bab_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bab_pkg::CFG_DATA_W-1:0] cfg_data
);

    logic                     s1_valid_reg;
    logic [1:0]               s1_req_reg;
    logic [ADC_BITS-1:0]      s1_sample_reg;
    logic                     out_valid_reg;
    logic                     out_pin_reg;
    logic                     out_alarm_reg;
    logic [bab_pkg::MV_W-1:0] out_mv_reg;
    bab_pkg::cfg_t            cfg_reg;
    logic                     advance;
    bab_pkg::step_t           step;
    logic                     pin_next, alarm_cur, alarm_next;
    logic [bab_pkg::MV_W-1:0] mv_cur, mv_next;

    // Stage handshake
    assign advance   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || advance;
    assign cfg_ready = 1'b1;

    // Request decode
    always_comb
    begin
        step.tick = advance && (s1_req_reg == bab_pkg::REQ_TICK);
        step.adc  = advance && (s1_req_reg == bab_pkg::REQ_ADC);
        step.beep = advance && (s1_req_reg == bab_pkg::REQ_BEEP);
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_req_reg    <= req_type;
            s1_sample_reg <= adc_sample;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_pin_reg   <= pin_next;
            out_alarm_reg <= alarm_next;
            out_mv_reg    <= mv_next;
        end
    end

    // Config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= bab_pkg::CFG_RESET;
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                bab_pkg::CFG_LOW_THRESHOLD:  cfg_reg.low_threshold_mv <= cfg_data[13:0];
                bab_pkg::CFG_LOW_HOLD:       cfg_reg.low_hold_ms <= cfg_data;
                bab_pkg::CFG_TICKS_PER_MS:   cfg_reg.ticks_per_ms <= cfg_data[3:0];
                bab_pkg::CFG_TONE_HALF:      cfg_reg.tone_half_ticks <= cfg_data[2:0];
                bab_pkg::CFG_CADENCE_ON:     cfg_reg.cadence_on_ticks <= cfg_data[13:0];
                bab_pkg::CFG_CADENCE_PERIOD: cfg_reg.cadence_period_ticks <= cfg_data[13:0];
                default:                     cfg_reg <= cfg_reg;
            endcase
        end
    end

    bab_adc #(
        .ADC_SAMPLES (ADC_SAMPLES),
        .ADC_BITS    (ADC_BITS)
    ) u_adc (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .sample  (s1_sample_reg),
        .mv      (mv_cur),
        .mv_next (mv_next)
    );

    bab_tone u_tone (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .cfg      (cfg_reg),
        .alarm    (alarm_cur),
        .pin_next (pin_next)
    );

    bab_ms u_ms (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .cfg        (cfg_reg),
        .voltage    (mv_cur),
        .alarm      (alarm_cur),
        .alarm_next (alarm_next)
    );

    assign out_valid    = out_valid_reg;
    assign buzzer_level = out_pin_reg;
    assign alarm_on     = out_alarm_reg;
    assign battery_mv   = out_mv_reg;

`ifndef SYNTHESIS
    // An empty result register never blocks the input side
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("input stalled with empty result register");

    // A full pipe with a stalled result refuses new items
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !out_ready) |-> !in_ready)
        else $error("item taken while pipe is full");

    // A result only appears after an item sat in the input register
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_valid_reg))
        else $error("result without an item");

    // An item in the input register moves on when the result side is free
    a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_valid_reg) |=> out_valid_reg)
        else $error("item did not advance");
`endif

endmodule

### sv/bab_adc.sv
// ADC sample accumulator and millivolt conversion.
module bab_adc #(
    parameter int ADC_SAMPLES = 8,
    parameter int ADC_BITS    = 10
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  bab_pkg::step_t            step,
    input  logic [ADC_BITS-1:0]       sample,
    output logic [bab_pkg::MV_W-1:0]  mv,
    output logic [bab_pkg::MV_W-1:0]  mv_next
);

    localparam int CNT_W  = (ADC_SAMPLES > 2) ? $clog2(ADC_SAMPLES) : 1;
    localparam int SUM_W  = ADC_BITS + CNT_W;
    localparam int PROD_W = ADC_BITS + bab_pkg::MV_NUM_W;
    localparam int SH_W   = PROD_W - bab_pkg::MV_SHIFT;
    localparam int MVF_W  = (SH_W > bab_pkg::MV_W) ? SH_W : bab_pkg::MV_W;

    logic [SUM_W-1:0]        sum_reg, sum_next, sum_add;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [bab_pkg::MV_W-1:0] mv_reg;
    logic [ADC_BITS-1:0]     mean;
    logic [PROD_W-1:0]       prod;
    logic [MVF_W-1:0]        mv_full;
    logic                    last;

    // Accumulate and convert on the last sample of a block
    always_comb
    begin
        sum_add = sum_reg + SUM_W'(sample);
        last    = (cnt_reg == CNT_W'(ADC_SAMPLES - 1));
        mean    = ADC_BITS'(sum_add / ADC_SAMPLES);
        prod    = PROD_W'(mean) * PROD_W'(bab_pkg::MV_NUM);
        mv_full = MVF_W'(prod >> bab_pkg::MV_SHIFT);
        sum_next = sum_reg;
        cnt_next = cnt_reg;
        mv_next  = mv_reg;
        if (step.adc)
        begin
            if (last)
            begin
                sum_next = '0;
                cnt_next = '0;
                if (mv_full > MVF_W'(bab_pkg::MV_MAX))
                    mv_next = bab_pkg::MV_MAX;
                else
                    mv_next = bab_pkg::MV_W'(mv_full);
            end
            else
            begin
                sum_next = sum_add;
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            cnt_reg <= '0;
            mv_reg  <= '0;
        end
        else
        begin
            sum_reg <= sum_next;
            cnt_reg <= cnt_next;
            mv_reg  <= mv_next;
        end
    end

    assign mv = mv_reg;

endmodule

### sv/bab_tone.sv
// Square tone generator and alarm on/off cadence.
module bab_tone (
    input  logic           clk,
    input  logic           rst_n,
    input  bab_pkg::step_t step,
    input  bab_pkg::cfg_t  cfg,
    input  logic           alarm,
    output logic           pin_next
);

    logic [3:0]  phase_reg, phase_next, p1, h2;
    logic [13:0] cad_reg, cad_next, c1;
    logic        en_reg, en_next;
    logic        pin_reg;

    always_comb
    begin
        phase_next = phase_reg;
        pin_next   = pin_reg;
        cad_next   = cad_reg;
        en_next    = en_reg;
        p1 = phase_reg + 4'd1;
        h2 = {cfg.tone_half_ticks, 1'b0};
        c1 = cad_reg + 14'd1;
        if (step.tick)
        begin
            // Tone runs on the enable as it stood before this tick
            if (en_reg)
            begin
                if (p1 <= {1'b0, cfg.tone_half_ticks})
                    pin_next = 1'b0;
                else if (p1 <= h2)
                    pin_next = 1'b1;
                phase_next = (p1 >= h2) ? 4'd0 : p1;
            end
            // Cadence gate
            if (!alarm)
            begin
                en_next  = 1'b0;
                cad_next = '0;
            end
            else if (c1 < cfg.cadence_on_ticks)
            begin
                en_next  = 1'b1;
                cad_next = c1;
            end
            else if (c1 < cfg.cadence_period_ticks)
            begin
                en_next  = 1'b0;
                cad_next = c1;
            end
            else
            begin
                cad_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
            cad_reg   <= '0;
            en_reg    <= 1'b0;
            pin_reg   <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            cad_reg   <= cad_next;
            en_reg    <= en_next;
            pin_reg   <= pin_next;
        end
    end

endmodule

### sv/bab_ms.sv
// Millisecond divider, low-battery hold counter and double beep sequencer.
module bab_ms (
    input  logic                     clk,
    input  logic                     rst_n,
    input  bab_pkg::step_t           step,
    input  bab_pkg::cfg_t            cfg,
    input  logic [bab_pkg::MV_W-1:0] voltage,
    output logic                     alarm,
    output logic                     alarm_next
);

    logic [3:0]  sub_reg, sub_next, s1;
    logic [15:0] low_reg, low_next;
    logic [7:0]  seq_reg, seq_next, b1;
    logic        active_reg, active_next;
    logic        alarm_reg;

    always_comb
    begin
        sub_next    = sub_reg;
        low_next    = low_reg;
        seq_next    = seq_reg;
        active_next = active_reg;
        alarm_next  = alarm_reg;
        s1 = sub_reg + 4'd1;
        b1 = seq_reg + 8'd1;
        if (step.beep)
            active_next = 1'b1;
        if (step.tick)
        begin
            if (s1 >= cfg.ticks_per_ms)
            begin
                sub_next = '0;
                // One millisecond step
                if (voltage < cfg.low_threshold_mv)
                begin
                    if (low_reg != bab_pkg::LOW_MS_MAX)
                        low_next = low_reg + 16'd1;
                    if (low_next > cfg.low_hold_ms)
                        alarm_next = 1'b1;
                end
                else
                begin
                    low_next = '0;
                    if (active_reg)
                    begin
                        alarm_next = 1'b1;
                        if (b1 > bab_pkg::BEEP_GAP_START && b1 < bab_pkg::BEEP_ON2_START)
                            active_next = 1'b0;
                        if (b1 >= bab_pkg::BEEP_END)
                        begin
                            seq_next    = '0;
                            active_next = 1'b0;
                        end
                        else
                            seq_next = b1;
                    end
                    else if (seq_reg != 8'd0)
                    begin
                        seq_next = b1;
                        if (b1 >= bab_pkg::BEEP_ON2_START && b1 < bab_pkg::BEEP_END)
                        begin
                            active_next = 1'b1;
                            alarm_next  = 1'b1;
                        end
                        else
                            alarm_next = 1'b0;
                    end
                    else
                        alarm_next = 1'b0;
                end
            end
            else
                sub_next = s1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sub_reg    <= '0;
            low_reg    <= '0;
            seq_reg    <= '0;
            active_reg <= 1'b0;
            alarm_reg  <= 1'b0;
        end
        else
        begin
            sub_reg    <= sub_next;
            low_reg    <= low_next;
            seq_reg    <= seq_next;
            active_reg <= active_next;
            alarm_reg  <= alarm_next;
        end
    end

    assign alarm = alarm_reg;

`ifndef SYNTHESIS
    // The beep timeline never reaches its end value without restarting
    a_seq_range: assert property (@(posedge clk) disable iff (!rst_n)
        seq_reg < bab_pkg::BEEP_END)
        else $error("beep sequence counter out of range");
`endif

endmodule

### test/battery_alarm_beeper_core_tb.sv
// Self-checking testbench for battery_alarm_beeper_core with a built-in behavioral predictor.
module battery_alarm_beeper_core_tb;
    import bab_pkg::*;

    localparam int ADC_SAMPLES     = 8;
    localparam int ADC_BITS        = 10;
    localparam int LATENCY         = 2;
    localparam int CYCLE_LIMIT     = 600000;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int RANDOM_ITEMS    = 1600;
    localparam int RUN_CAP         = 500;
    localparam int MAX_LINES       = 40;

    // One result item as the block reports it
    typedef struct packed {
        logic            level;
        logic            alarm;
        logic [MV_W-1:0] mv;
    } buzzer_out_t;

    // Scoreboard: tracks the beeper state and the results still owed by the block
    class beeper_scoreboard;
        cfg_t        regs;
        bit [3:0]    tone_phase;
        bit [13:0]   cadence_count;
        bit          tone_enable;
        bit          pin_level;
        bit [3:0]    sub_ms_count;
        bit [15:0]   low_ms_count;
        bit [7:0]    beep_ms;
        bit          beep_active;
        bit          alarm;
        bit [12:0]   adc_sum;
        bit [2:0]    adc_count;
        bit [13:0]   voltage_mv;
        buzzer_out_t pending_outputs[$];
        int          errors;

        function new();
            regs          = CFG_RESET;
            tone_phase    = '0;
            cadence_count = '0;
            tone_enable   = 1'b0;
            pin_level     = 1'b0;
            sub_ms_count  = '0;
            low_ms_count  = '0;
            beep_ms       = '0;
            beep_active   = 1'b0;
            alarm         = 1'b0;
            adc_sum       = '0;
            adc_count     = '0;
            voltage_mv    = '0;
            errors        = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_LOW_THRESHOLD:  regs.low_threshold_mv     = data[13:0];
                CFG_LOW_HOLD:       regs.low_hold_ms          = data;
                CFG_TICKS_PER_MS:   regs.ticks_per_ms         = data[3:0];
                CFG_TONE_HALF:      regs.tone_half_ticks      = data[2:0];
                CFG_CADENCE_ON:     regs.cadence_on_ticks     = data[13:0];
                CFG_CADENCE_PERIOD: regs.cadence_period_ticks = data[13:0];
                default: ;
            endcase
        endfunction

        // Square tone on the old enable, then the alarm cadence gate
        function void tone_step();
            bit [4:0] full_period;
            full_period = {1'b0, regs.tone_half_ticks, 1'b0};
            if (tone_enable)
            begin
                tone_phase = tone_phase + 4'd1;
                if (tone_phase <= regs.tone_half_ticks)
                    pin_level = 1'b0;
                else if ({1'b0, tone_phase} <= full_period)
                    pin_level = 1'b1;
                if ({1'b0, tone_phase} >= full_period)
                    tone_phase = '0;
            end
            if (!alarm)
            begin
                tone_enable   = 1'b0;
                cadence_count = '0;
            end
            else
            begin
                cadence_count = cadence_count + 14'd1;
                if (cadence_count < regs.cadence_on_ticks)
                    tone_enable = 1'b1;
                else if (cadence_count < regs.cadence_period_ticks)
                    tone_enable = 1'b0;
                else
                    cadence_count = '0;
            end
        endfunction

        // One millisecond of low-voltage watch and double-beep sequencing
        function void ms_step();
            if (voltage_mv < regs.low_threshold_mv)
            begin
                if (low_ms_count != LOW_MS_MAX)
                    low_ms_count = low_ms_count + 16'd1;
                if (low_ms_count > regs.low_hold_ms)
                    alarm = 1'b1;
                return;
            end
            low_ms_count = '0;
            if (beep_active)
            begin
                alarm   = 1'b1;
                beep_ms = beep_ms + 8'd1;
                if (beep_ms > BEEP_GAP_START && beep_ms < BEEP_ON2_START)
                    beep_active = 1'b0;
                if (beep_ms >= BEEP_END)
                begin
                    beep_ms     = '0;
                    beep_active = 1'b0;
                end
                return;
            end
            if (beep_ms != 8'd0)
            begin
                beep_ms = beep_ms + 8'd1;
                if (beep_ms >= BEEP_ON2_START && beep_ms < BEEP_END)
                begin
                    beep_active = 1'b1;
                    alarm       = 1'b1;
                    return;
                end
            end
            alarm = 1'b0;
        endfunction

        // Accumulate samples; a full set becomes the new millivolt reading
        function void adc_step(logic [ADC_BITS-1:0] smp);
            int unsigned mv;
            adc_sum = adc_sum + smp;
            if (int'(adc_count) + 1 >= ADC_SAMPLES)
            begin
                mv         = (int'(adc_sum) / ADC_SAMPLES) * MV_NUM / (1 << MV_SHIFT);
                voltage_mv = (mv > MV_MAX) ? MV_MAX : mv[MV_W-1:0];
                adc_sum    = '0;
                adc_count  = '0;
            end
            else
                adc_count = adc_count + 3'd1;
        endfunction

        // Accepted input item: advance the state and queue the result it owes
        function void note_item(req_t req, logic [ADC_BITS-1:0] smp);
            buzzer_out_t owed;
            case (req)
                REQ_TICK:
                begin
                    tone_step();
                    sub_ms_count = sub_ms_count + 4'd1;
                    if (sub_ms_count >= regs.ticks_per_ms)
                    begin
                        sub_ms_count = '0;
                        ms_step();
                    end
                end
                REQ_ADC:  adc_step(smp);
                REQ_BEEP: beep_active = 1'b1;
                default: ;
            endcase
            owed.level = pin_level;
            owed.alarm = alarm;
            owed.mv    = voltage_mv;
            pending_outputs.push_back(owed);
        endfunction

        task report(string what, int got, int want);
            errors++;
            if (errors <= MAX_LINES)
                $display("MISMATCH at %0t: %s got %0d want %0d", $time, what, got, want);
        endtask

        task check_result(logic level, logic alm, logic [MV_W-1:0] mv);
            buzzer_out_t want;
            if (pending_outputs.size() == 0)
            begin
                report("result with none pending", 0, 0);
                return;
            end
            want = pending_outputs.pop_front();
            if (level !== want.level)
                report("buzzer_level", level, want.level);
            if (alm !== want.alarm)
                report("alarm_on", alm, want.alarm);
            if (mv !== want.mv)
                report("battery_mv", mv, want.mv);
        endtask

        function int pending();
            return pending_outputs.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [1:0]            req_type;
    logic [ADC_BITS-1:0]   adc_sample;
    logic                  out_valid;
    logic                  out_ready;
    logic                  buzzer_level;
    logic                  alarm_on;
    logic [MV_W-1:0]       battery_mv;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    beeper_scoreboard sb;
    int  items_sent  = 0;
    int  burst_left  = 0;
    int  cycle_count = 0;
    bit  tx_idle     = 1'b1;
    bit  rx_stall_on = 1'b1;
    bit  hold_off_start = 1'b0;

    battery_alarm_beeper_core #(
        .ADC_SAMPLES (ADC_SAMPLES),
        .ADC_BITS    (ADC_BITS)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .adc_sample   (adc_sample),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .buzzer_level (buzzer_level),
        .alarm_on     (alarm_on),
        .battery_mv   (battery_mv),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Handshake monitor: register writes, accepted items, returned results
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
            if (in_valid && in_ready)
                sb.note_item(req_t'(req_type), adc_sample);
            if (out_valid && out_ready)
                sb.check_result(buzzer_level, alarm_on, battery_mv);
        end
    end

    // Result side: random stall pattern, plus a long hold-off on request
    initial
    begin : rx_side
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_off_start)
            begin
                hold_off_start = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            else if (rx_stall_on && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                repeat (rx_stall_on ? $urandom_range(1, 8) : 1) @(posedge clk);
            end
        end
    end

    function automatic logic [ADC_BITS-1:0] rand_sample();
        return ADC_BITS'($urandom);
    endfunction

    // Random junk above a register's width, which the block must drop
    function automatic logic [CFG_DATA_W-1:0] with_junk(input int unsigned val, input int w);
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'($urandom);
        if (w >= CFG_DATA_W || $urandom_range(0, 1) == 0)
            return val[CFG_DATA_W-1:0];
        return val[CFG_DATA_W-1:0] | (junk << w);
    endfunction

    // Offer one item, with burst/gap pacing, and wait until it is taken
    task automatic drive_item(input req_t req, input logic [ADC_BITS-1:0] smp);
        int gap;
        if (tx_idle && burst_left == 0)
        begin
            gap        = $urandom_range(1, 8);
            burst_left = $urandom_range(1, 12);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        if (burst_left > 0)
            burst_left--;
        in_valid   <= 1'b1;
        req_type   <= req;
        adc_sample <= smp;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (req != REQ_NONE)
            items_sent++;
    endtask

    // Stop sending and wait for every owed result, then let the pipe settle
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (LATENCY + 3) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    // Write all six registers while the block is idle
    task automatic program_regs(input logic [CFG_DATA_W-1:0] thr, hold, tpm, half,
                                input logic [CFG_DATA_W-1:0] on_ticks, period);
        drain();
        write_cfg(CFG_LOW_THRESHOLD, thr);
        write_cfg(CFG_LOW_HOLD, hold);
        write_cfg(CFG_TICKS_PER_MS, tpm);
        write_cfg(CFG_TONE_HALF, half);
        write_cfg(CFG_CADENCE_ON, on_ticks);
        write_cfg(CFG_CADENCE_PERIOD, period);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic adc_set(input int lo, input int hi, input int count);
        repeat (count) drive_item(REQ_ADC, ADC_BITS'($urandom_range(hi, lo)));
    endtask

    function automatic int ticks_per_ms_now();
        return (sb.regs.ticks_per_ms == 0) ? 1 : int'(sb.regs.ticks_per_ms);
    endfunction

    // High battery, a beep request, then ticks aimed at the full double beep, capped at RUN_CAP items
    task automatic beep_run();
        int n;
        adc_set(800, 1023, ADC_SAMPLES);
        drive_item(REQ_BEEP, rand_sample());
        n = 215 * ticks_per_ms_now() + $urandom_range(0, 20);
        if (n > RUN_CAP)
            n = RUN_CAP;
        repeat (n)
        begin
            case ($urandom_range(0, 59))
                0:       drive_item(REQ_BEEP, rand_sample());
                1:       drive_item(REQ_NONE, rand_sample());
                default: drive_item(REQ_TICK, rand_sample());
            endcase
        end
    endtask

    // Low battery aimed at raising the alarm and running the cadence (capped at RUN_CAP items), then recover
    task automatic alarm_run();
        int n;
        adc_set(0, 200, ADC_SAMPLES);
        n = (int'(sb.regs.low_hold_ms) + 3) * ticks_per_ms_now() + $urandom_range(20, 120);
        if (n > RUN_CAP)
            n = RUN_CAP;
        repeat (n)
        begin
            case ($urandom_range(0, 79))
                0:       drive_item(REQ_BEEP, rand_sample());
                1:       drive_item(REQ_NONE, rand_sample());
                default: drive_item(REQ_TICK, rand_sample());
            endcase
        end
        adc_set(800, 1023, ADC_SAMPLES);
        repeat ($urandom_range(5, 30)) drive_item(REQ_TICK, rand_sample());
    endtask

    // Any request code, any sample, including partial ADC sets
    task automatic noise_run();
        repeat ($urandom_range(5, 25))
            drive_item(req_t'($urandom_range(0, 3)), rand_sample());
    endtask

    // Main sequence
    initial
    begin : stimulus
        int phase;
        int pick;
        int tpm;
        sb = new();
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        req_type   <= REQ_TICK;
        adc_sample <= '0;
        cfg_valid  <= 1'b0;
        cfg_index  <= CFG_LOW_THRESHOLD;
        cfg_data   <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset settings, then per-ms stepping on every tick,
        // zero half period, cadence wrap, and a beep during a beep
        drive_item(REQ_NONE, {ADC_BITS{1'b1}});
        drive_item(REQ_TICK, '0);
        drive_item(REQ_ADC, {ADC_BITS{1'b1}});
        program_regs(16'd1000, 16'd0, 16'd0, 16'd0, 16'd2, 16'd1);
        repeat (3)
        begin
            drive_item(REQ_ADC, '0);
            drive_item(REQ_ADC, {ADC_BITS{1'b1}});
        end
        drive_item(REQ_ADC, '0);
        drive_item(REQ_BEEP, '0);
        repeat (3) drive_item(REQ_TICK, rand_sample());
        drive_item(REQ_BEEP, '0);
        repeat (7) drive_item(REQ_TICK, rand_sample());

        // Random phases, each with its own settings and pacing
        items_sent = 0;
        for (phase = 0; items_sent < RANDOM_ITEMS; phase++)
        begin
            if (phase == 0)
                program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
            else if (phase == 1)
                program_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
            else
            begin
                case ($urandom_range(0, 5))
                    0:       tpm = 0;
                    1, 2:    tpm = 1;
                    3, 4:    tpm = 2;
                    default: tpm = 3;
                endcase
                program_regs(with_junk($urandom_range(3000, 11000), 14),
                             with_junk($urandom_range(0, 15), 16),
                             with_junk(tpm, 4),
                             with_junk($urandom_range(0, 7), 3),
                             with_junk($urandom_range(0, 25), 14),
                             with_junk($urandom_range(0, 40), 14));
            end
            tx_idle     = (phase % 4 != 3);
            rx_stall_on = (phase % 5 != 4);
            // Receiver holds off while the sender keeps pushing
            if (phase == 2 || $urandom_range(0, 5) == 0)
            begin
                tx_idle        = 1'b0;
                hold_off_start = 1'b1;
            end
            repeat (3)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 4)
                    alarm_run();
                else if (pick < 7 && phase != 0)
                    beep_run();
                else
                    noise_run();
                if ($urandom_range(0, 7) == 0)
                    drain();
            end
        end

        drain();
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### filelist.f
sv/bab_pkg.sv
sv/bab_adc.sv
sv/bab_tone.sv
sv/bab_ms.sv
sv/battery_alarm_beeper_core.sv
test/battery_alarm_beeper_core_tb.sv
